@@ hw/rtl/pid_speed_loop_hbridge_pwm_defines.svh @@
// Assertion macros for the speed loop block.
`ifndef PID_SPEED_LOOP_HBRIDGE_PWM_DEFINES_SVH
`define PID_SPEED_LOOP_HBRIDGE_PWM_DEFINES_SVH

// Same-cycle implication, clocked on i_clk, off during reset.
`define PSL_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on i_clk, off during reset.
`define PSL_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/psl_pkg.sv @@
`default_nettype none

package psl_pkg;

    localparam int GAIN_SCALE   = 1000;
    localparam int OUTPUT_LIMIT = 999;
    localparam int MIN_OUTPUT   = 50;
    localparam int PWM_PERIOD   = 1000;
    localparam int DUTY_TOP     = PWM_PERIOD - 1;

    localparam int T_W    = 16;
    localparam int ERR_W  = 17;
    localparam int ESUM_W = 24;
    localparam int DER_W  = 18;
    localparam int GAIN_W = 16;
    localparam int LIM_W  = 10;
    localparam int IL_W   = 23;
    localparam int LTL_W  = 15;
    localparam int DRV_W  = 11;
    localparam int CMP_W  = 10;
    localparam int PER_W  = $clog2(PWM_PERIOD + 1);

    localparam int PP_W  = GAIN_W + ERR_W;
    localparam int PI_W  = GAIN_W + ESUM_W;
    localparam int PD_W  = GAIN_W + DER_W;
    localparam int SUM_W = PI_W + 1;
    localparam int ABS_W = SUM_W - 1;

    // Sums at or above this threshold divide to more than any output limit.
    localparam longint SAT_TH    = longint'(GAIN_SCALE) * longint'(OUTPUT_LIMIT + 1);
    localparam int     REC_IN_W  = $clog2(SAT_TH);
    localparam int     REC_SHIFT = REC_IN_W + $clog2(GAIN_SCALE);
    localparam longint REC_MUL   = ((longint'(1) << REC_SHIFT) + GAIN_SCALE - 1) / GAIN_SCALE;
    localparam int     REC_MUL_W = $clog2(REC_MUL + 1);
    localparam int     REC_P_W   = REC_IN_W + REC_MUL_W;
    localparam int     Q_W       = $clog2(OUTPUT_LIMIT + 2);

    localparam int NSTG = 7;

    localparam int ADDR_W = 5;
    localparam int DATA_W = 32;
    localparam logic [2:0] REG_KP   = 3'd0;
    localparam logic [2:0] REG_KI   = 3'd1;
    localparam logic [2:0] REG_KD   = 3'd2;
    localparam logic [2:0] REG_MAXS = 3'd3;
    localparam logic [2:0] REG_REV  = 3'd4;
    localparam logic [2:0] REG_ILIM = 3'd5;
    localparam logic [2:0] REG_LTL  = 3'd6;
    localparam logic [2:0] REG_LTOL = 3'd7;

    typedef struct packed {
        logic signed [GAIN_W-1:0] kp;
        logic signed [GAIN_W-1:0] ki;
        logic signed [GAIN_W-1:0] kd;
        logic [LIM_W-1:0]         duty_cap;
        logic                     reverse_drive;
        logic [IL_W-1:0]          integral_limit;
        logic [LTL_W-1:0]         low_target_limit;
        logic [LIM_W-1:0]         low_target_output_limit;
    } t_cfg;

    typedef struct packed {
        logic                    tz;
        logic                    tneg;
        logic [LIM_W-1:0]        lim;
        logic signed [ERR_W-1:0] err;
    } t_ctl;

    typedef struct packed {
        t_ctl                     ctl;
        logic signed [ESUM_W-1:0] esum;
        logic signed [DER_W-1:0]  der;
    } t_s2;

    typedef struct packed {
        t_ctl                  ctl;
        logic                  neg;
        logic                  big;
        logic [REC_IN_W-1:0]   mag;
    } t_s5;

    typedef struct packed {
        t_ctl           ctl;
        logic           neg;
        logic [Q_W-1:0] q;
    } t_s6;

    function automatic logic [LIM_W-1:0] duty_ceiling(input logic [LIM_W-1:0] cap);
        if (cap > LIM_W'(DUTY_TOP)) begin
            return LIM_W'(DUTY_TOP);
        end
        return cap;
    endfunction

endpackage

`default_nettype wire

@@ hw/rtl/psl_state.sv @@
`default_nettype none

module psl_state (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_fire,
    input  wire logic signed [15:0]         i_target,
    input  wire logic signed [15:0]         i_measured,
    input  wire psl_pkg::t_cfg              i_cfg,
    output psl_pkg::t_s2                    o_s2
);
    import psl_pkg::*;

    logic signed [T_W-1:0]    r_last;
    logic signed [ESUM_W-1:0] r_esum;
    logic signed [ERR_W-1:0]  r_prior;
    logic                     r_dr;
    t_s2                      r_s2;
    t_s2                      n_s2;

    logic                     tz;
    logic                     flip;
    logic                     clr;
    logic signed [ERR_W-1:0]  t_ext;
    logic signed [ERR_W-1:0]  m_ext;
    logic signed [ERR_W-1:0]  err;
    logic signed [ESUM_W:0]   acc;
    logic signed [ESUM_W:0]   il_s;
    logic signed [ESUM_W-1:0] esum;
    logic signed [DER_W-1:0]  der;
    logic [T_W-1:0]           tabs;
    logic [LIM_W-1:0]         lim_a;
    logic [LIM_W-1:0]         lim;

    always_comb begin
        tz    = (i_target == '0);
        flip  = (!r_last[T_W-1] && (r_last != '0) && (i_target[T_W-1] || tz)) ||
                (r_last[T_W-1] && !i_target[T_W-1]);
        clr   = flip || tz;
        t_ext = ERR_W'(i_target);
        m_ext = ERR_W'(i_measured);
        err   = tz ? -m_ext : (t_ext - m_ext);

        acc  = (clr ? (ESUM_W+1)'(0) : (ESUM_W+1)'(r_esum)) + (ESUM_W+1)'(err);
        il_s = $signed({2'b00, i_cfg.integral_limit});
        if (acc > il_s) begin
            esum = ESUM_W'(il_s);
        end else if (acc < -il_s) begin
            esum = ESUM_W'(-il_s);
        end else begin
            esum = ESUM_W'(acc);
        end

        if (r_dr && !clr) begin
            der = DER_W'(err) - DER_W'(r_prior);
        end else begin
            der = '0;
        end

        lim_a = duty_ceiling(i_cfg.duty_cap);
        if (lim_a > LIM_W'(OUTPUT_LIMIT)) begin
            lim_a = LIM_W'(OUTPUT_LIMIT);
        end
        tabs = i_target[T_W-1] ? T_W'(-i_target) : T_W'(i_target);
        lim  = lim_a;
        if ((tabs <= {1'b0, i_cfg.low_target_limit}) &&
            (lim_a > i_cfg.low_target_output_limit)) begin
            lim = i_cfg.low_target_output_limit;
        end

        n_s2.ctl.tz   = tz;
        n_s2.ctl.tneg = i_target[T_W-1];
        n_s2.ctl.lim  = lim;
        n_s2.ctl.err  = err;
        n_s2.esum     = esum;
        n_s2.der      = der;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last  <= '0;
            r_esum  <= '0;
            r_prior <= '0;
            r_dr    <= 1'b0;
        end else if (i_fire) begin
            r_last <= i_target;
            if (tz) begin
                r_esum  <= '0;
                r_prior <= '0;
                r_dr    <= 1'b0;
            end else begin
                r_esum  <= esum;
                r_prior <= err;
                r_dr    <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_fire) begin
            r_s2 <= n_s2;
        end
    end

    assign o_s2 = r_s2;

endmodule

`default_nettype wire

@@ hw/rtl/psl_mac.sv @@
`default_nettype none

module psl_mac (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire psl_pkg::t_s2  i_s2,
    input  wire psl_pkg::t_cfg i_cfg,
    output psl_pkg::t_s5       o_s5
);
    import psl_pkg::*;

    logic signed [PP_W-1:0]  r_pp;
    logic signed [PI_W-1:0]  r_pi;
    logic signed [PD_W-1:0]  r_pd;
    t_ctl                    r_ctl3;
    logic signed [SUM_W-1:0] r_sum;
    t_ctl                    r_ctl4;
    t_s5                     r_s5;

    logic signed [PP_W-1:0]  n_pp;
    logic signed [PI_W-1:0]  n_pi;
    logic signed [PD_W-1:0]  n_pd;
    logic signed [SUM_W-1:0] n_sum;
    logic [ABS_W-1:0]        abs_sum;
    t_s5                     n_s5;

    always_comb begin
        n_pp  = PP_W'(i_cfg.kp) * PP_W'(i_s2.ctl.err);
        n_pi  = PI_W'(i_cfg.ki) * PI_W'(i_s2.esum);
        n_pd  = PD_W'(i_cfg.kd) * PD_W'(i_s2.der);
        n_sum = SUM_W'(r_pp) + SUM_W'(r_pi) + SUM_W'(r_pd);

        abs_sum  = r_sum[SUM_W-1] ? ABS_W'(-r_sum) : ABS_W'(r_sum);
        n_s5.ctl = r_ctl4;
        n_s5.neg = r_sum[SUM_W-1];
        n_s5.big = (abs_sum >= ABS_W'(SAT_TH));
        n_s5.mag = abs_sum[REC_IN_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_pp   <= n_pp;
            r_pi   <= n_pi;
            r_pd   <= n_pd;
            r_ctl3 <= i_s2.ctl;
            r_sum  <= n_sum;
            r_ctl4 <= r_ctl3;
            r_s5   <= n_s5;
        end
    end

    assign o_s5 = r_s5;

endmodule

`default_nettype wire

@@ hw/rtl/psl_div.sv @@
`default_nettype none

module psl_div (
    input  wire logic         i_clk,
    input  wire logic         i_en,
    input  wire psl_pkg::t_s5 i_s5,
    output psl_pkg::t_s6      o_s6
);
    import psl_pkg::*;

    t_s6                r_s6;
    t_s6                n_s6;
    logic [REC_P_W-1:0] prod;

    // Exact floor division of the sum's magnitude by the gain scale, for sums below the saturation threshold.
    always_comb begin
        prod     = REC_P_W'(i_s5.mag) * REC_P_W'(REC_MUL);
        n_s6.ctl = i_s5.ctl;
        n_s6.neg = i_s5.neg;
        n_s6.q   = i_s5.big ? Q_W'(OUTPUT_LIMIT + 1) : prod[REC_SHIFT +: Q_W];
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s6 <= n_s6;
        end
    end

    assign o_s6 = r_s6;

endmodule

`default_nettype wire

@@ hw/rtl/psl_out.sv @@
`default_nettype none

module psl_out (
    input  wire logic          i_clk,
    input  wire logic          i_en,
    input  wire psl_pkg::t_s6  i_s6,
    input  wire psl_pkg::t_cfg i_cfg,
    output logic signed [10:0] o_drive,
    output logic signed [16:0] o_speed_error,
    output logic [9:0]         o_in1_compare,
    output logic [9:0]         o_in2_compare
);
    import psl_pkg::*;

    logic signed [DRV_W-1:0] r_drive;
    logic signed [ERR_W-1:0] r_err;
    logic [CMP_W-1:0]        r_c1;
    logic [CMP_W-1:0]        r_c2;

    logic [Q_W-1:0]          lim;
    logic [Q_W-1:0]          mag;
    logic [LIM_W-1:0]        ceil_d;
    logic [PER_W-1:0]        pmag;
    logic [CMP_W-1:0]        active;
    logic                    map_neg;
    logic signed [DRV_W-1:0] n_drive;
    logic [CMP_W-1:0]        n_c1;
    logic [CMP_W-1:0]        n_c2;

    always_comb begin
        lim = Q_W'(i_s6.ctl.lim);
        mag = (i_s6.q > lim) ? lim : i_s6.q;
        // no reversal against the target direction
        if ((mag != '0) && (i_s6.neg != i_s6.ctl.tneg)) begin
            mag = '0;
        end
        if ((mag != '0) && (mag < Q_W'(MIN_OUTPUT))) begin
            mag = Q_W'(MIN_OUTPUT);
        end
        if (mag > lim) begin
            mag = lim;
        end
        if (i_s6.ctl.tz) begin
            mag = '0;
        end
        n_drive = i_s6.neg ? -DRV_W'(mag) : DRV_W'(mag);

        ceil_d  = duty_ceiling(i_cfg.duty_cap);
        pmag    = (PER_W'(mag) > PER_W'(ceil_d)) ? PER_W'(ceil_d) : PER_W'(mag);
        active  = CMP_W'(PER_W'(PWM_PERIOD) - pmag);
        map_neg = i_s6.neg ^ i_cfg.reverse_drive;
        if (mag == '0) begin
            n_c1 = CMP_W'(PWM_PERIOD);
            n_c2 = CMP_W'(PWM_PERIOD);
        end else if (!map_neg) begin
            n_c1 = CMP_W'(PWM_PERIOD);
            n_c2 = active;
        end else begin
            n_c1 = active;
            n_c2 = CMP_W'(PWM_PERIOD);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_drive <= n_drive;
            r_err   <= i_s6.ctl.err;
            r_c1    <= n_c1;
            r_c2    <= n_c2;
        end
    end

    assign o_drive       = r_drive;
    assign o_speed_error = r_err;
    assign o_in1_compare = r_c1;
    assign o_in2_compare = r_c2;

endmodule

`default_nettype wire

@@ hw/rtl/pid_speed_loop_hbridge_pwm.sv @@
// PID speed loop for one H-bridge motor. Each transaction on the input channel carries a
// target and a measured speed and yields exactly one result transaction (drive, speed error
// and the two slow-decay PWM compare values), in order; a new transaction is taken every
// cycle while o_stall is low. The integral and derivative state is updated in the
// second stage, so back-to-back transactions see each other's state with no gap. The
// pipeline moves as one: while a result sits unaccepted under i_stall, o_stall is high and
// nothing advances. Registers (APB, 32-bit, byte address 4*i): kp, ki, kd, duty_cap,
// reverse_drive, integral_limit, low_target_limit, low_target_output_limit. Write them only
// while idle.
`default_nettype none

`include "pid_speed_loop_hbridge_pwm_defines.svh"

module pid_speed_loop_hbridge_pwm (
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_valid,
    output logic                            o_stall,
    input  wire logic signed [15:0]         i_target,
    input  wire logic signed [15:0]         i_measured,
    output logic                            o_valid,
    input  wire logic                       i_stall,
    output logic signed [10:0]              o_drive,
    output logic signed [16:0]              o_speed_error,
    output logic [9:0]                      o_in1_compare,
    output logic [9:0]                      o_in2_compare,
    input  wire logic                       psel,
    input  wire logic                       penable,
    input  wire logic                       pwrite,
    input  wire logic [psl_pkg::ADDR_W-1:0] paddr,
    input  wire logic [psl_pkg::DATA_W-1:0] pwdata,
    output logic [psl_pkg::DATA_W-1:0]      prdata,
    output logic                            pready
);
    import psl_pkg::*;

    t_cfg                  r_cfg;
    logic [NSTG-1:0]       r_vld;
    logic signed [T_W-1:0] r_t;
    logic signed [T_W-1:0] r_m;

    logic                  en;
    logic                  cfg_wr;
    t_s2                   s2;
    t_s5                   s5;
    t_s6                   s6;
    logic                  stop_cmd;
    logic                  stop_ok;
    logic                  drive_ok;

    assign en      = !(r_vld[NSTG-1] && i_stall);
    assign o_stall = !en;
    assign o_valid = r_vld[NSTG-1];
    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.kp                      <= '0;
            r_cfg.ki                      <= '0;
            r_cfg.kd                      <= '0;
            r_cfg.duty_cap                <= LIM_W'(999);
            r_cfg.reverse_drive           <= 1'b0;
            r_cfg.integral_limit          <= '1;
            r_cfg.low_target_limit        <= '0;
            r_cfg.low_target_output_limit <= LIM_W'(999);
        end else if (cfg_wr) begin
            unique case (paddr[4:2])
                REG_KP:   r_cfg.kp                      <= pwdata[GAIN_W-1:0];
                REG_KI:   r_cfg.ki                      <= pwdata[GAIN_W-1:0];
                REG_KD:   r_cfg.kd                      <= pwdata[GAIN_W-1:0];
                REG_MAXS: r_cfg.duty_cap                <= pwdata[LIM_W-1:0];
                REG_REV:  r_cfg.reverse_drive           <= pwdata[0];
                REG_ILIM: r_cfg.integral_limit          <= pwdata[IL_W-1:0];
                REG_LTL:  r_cfg.low_target_limit        <= pwdata[LTL_W-1:0];
                REG_LTOL: r_cfg.low_target_output_limit <= pwdata[LIM_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[4:2])
            REG_KP:   prdata = DATA_W'(r_cfg.kp);
            REG_KI:   prdata = DATA_W'(r_cfg.ki);
            REG_KD:   prdata = DATA_W'(r_cfg.kd);
            REG_MAXS: prdata = DATA_W'(r_cfg.duty_cap);
            REG_REV:  prdata = DATA_W'(r_cfg.reverse_drive);
            REG_ILIM: prdata = DATA_W'(r_cfg.integral_limit);
            REG_LTL:  prdata = DATA_W'(r_cfg.low_target_limit);
            REG_LTOL: prdata = DATA_W'(r_cfg.low_target_output_limit);
            default:  prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (en) begin
            r_vld <= {r_vld[NSTG-2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        if (en && i_valid) begin
            r_t <= i_target;
            r_m <= i_measured;
        end
    end

    psl_state u_state (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_fire     (en && r_vld[0]),
        .i_target   (r_t),
        .i_measured (r_m),
        .i_cfg      (r_cfg),
        .o_s2       (s2)
    );

    psl_mac u_mac (
        .i_clk (i_clk),
        .i_en  (en),
        .i_s2  (s2),
        .i_cfg (r_cfg),
        .o_s5  (s5)
    );

    psl_div u_div (
        .i_clk (i_clk),
        .i_en  (en),
        .i_s5  (s5),
        .o_s6  (s6)
    );

    psl_out u_out (
        .i_clk         (i_clk),
        .i_en          (en),
        .i_s6          (s6),
        .i_cfg         (r_cfg),
        .o_drive       (o_drive),
        .o_speed_error (o_speed_error),
        .o_in1_compare (o_in1_compare),
        .o_in2_compare (o_in2_compare)
    );

    assign stop_cmd = o_valid && (o_drive == '0);
    assign stop_ok  = (o_in1_compare == CMP_W'(PWM_PERIOD)) &&
                      (o_in2_compare == CMP_W'(PWM_PERIOD));
    assign drive_ok = (o_drive <= DRV_W'(OUTPUT_LIMIT)) && (o_drive >= -DRV_W'(OUTPUT_LIMIT));

    `PSL_ASSERT_NOW(a_stop_both_high, stop_cmd, stop_ok, "zero drive without stop state")
    `PSL_ASSERT_NOW(a_drive_bound, o_valid, drive_ok, "drive beyond output limit")
    `PSL_ASSERT_NOW(a_no_stall_empty, !o_valid, !o_stall, "stall with empty output")
    `PSL_ASSERT_NEXT(a_result_lands, en && r_vld[NSTG-2], o_valid, "advancing result lost")

endmodule

`default_nettype wire

@@ dv/speed_loop_checker.sv @@
`timescale 1ns / 100ps

module speed_loop_checker (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    input  logic                       i_in_stall,
    input  logic signed [15:0]         i_target,
    input  logic signed [15:0]         i_measured,
    input  logic                       i_out_valid,
    input  logic                       i_out_stall,
    input  logic signed [10:0]         i_drive,
    input  logic signed [16:0]         i_speed_error,
    input  logic [9:0]                 i_in1_compare,
    input  logic [9:0]                 i_in2_compare,
    input  logic                       i_psel,
    input  logic                       i_penable,
    input  logic                       i_pwrite,
    input  logic                       i_pready,
    input  logic [psl_pkg::ADDR_W-1:0] i_paddr,
    input  logic [psl_pkg::DATA_W-1:0] i_pwdata,
    output int                         o_errors,
    output int                         o_pending
);
    import psl_pkg::*;

    typedef struct packed {
        logic signed [10:0] drive;
        logic signed [16:0] speed_error;
        logic [9:0]         in1_cmp;
        logic [9:0]         in2_cmp;
    } t_motor_cmd;

    t_cfg               cfg;
    logic signed [15:0] prev_target;
    longint             integ;
    longint             last_err;
    bit                 der_ok;
    t_motor_cmd         cmd_q[$];
    int                 fail_tally;

    function automatic t_motor_cmd next_motor_cmd(input logic signed [15:0] tgt,
                                                  input logic signed [15:0] meas);
        t_motor_cmd cmd;
        longint     t, m, err, der, acc, drv, lim, ceil_v, mapped, mag, il, ltl, ltol;
        longint     c1, c2;
        bit         sign_flip;
        t = tgt;
        m = meas;
        sign_flip = (prev_target > 0 && tgt <= 0) || (prev_target < 0 && tgt >= 0);
        prev_target = tgt;
        if (sign_flip || t == 0) begin
            integ = 0;
            last_err = 0;
            der_ok = 1'b0;
        end
        ceil_v = longint'(cfg.duty_cap);
        if (ceil_v > PWM_PERIOD - 1) ceil_v = PWM_PERIOD - 1;
        drv = 0;
        if (t == 0) begin
            err = -m;
        end else begin
            il = longint'(cfg.integral_limit);
            err = t - m;
            integ = integ + err;
            if (integ > il) integ = il;
            else if (integ < -il) integ = -il;
            if (der_ok) begin
                der = err - last_err;
            end else begin
                der = 0;
                der_ok = 1'b1;
            end
            last_err = err;
            acc = longint'($signed(cfg.kp)) * err + longint'($signed(cfg.ki)) * integ +
                  longint'($signed(cfg.kd)) * der;
            drv = acc / GAIN_SCALE;

            lim = ceil_v;
            if (lim > OUTPUT_LIMIT) lim = OUTPUT_LIMIT;
            ltl = longint'(cfg.low_target_limit);
            ltol = longint'(cfg.low_target_output_limit);
            if (t <= ltl && t >= -ltl && lim > ltol) lim = ltol;

            if (drv > lim) drv = lim;
            else if (drv < -lim) drv = -lim;
            // no reversal against the target direction
            if (t > 0 && drv < 0) drv = 0;
            else if (t < 0 && drv > 0) drv = 0;
            if (drv > 0 && drv < MIN_OUTPUT) drv = MIN_OUTPUT;
            else if (drv < 0 && drv > -MIN_OUTPUT) drv = -MIN_OUTPUT;
            if (drv > lim) drv = lim;
            else if (drv < -lim) drv = -lim;
        end

        mapped = cfg.reverse_drive ? -drv : drv;
        mag = (mapped < 0) ? -mapped : mapped;
        if (mag > ceil_v) mag = ceil_v;
        if (mapped > 0) begin
            c1 = PWM_PERIOD;
            c2 = PWM_PERIOD - mag;
        end else if (mapped < 0) begin
            c1 = PWM_PERIOD - mag;
            c2 = PWM_PERIOD;
        end else begin
            // stop: both bridge inputs high
            c1 = PWM_PERIOD;
            c2 = PWM_PERIOD;
        end

        cmd.drive = drv[10:0];
        cmd.speed_error = err[16:0];
        cmd.in1_cmp = c1[9:0];
        cmd.in2_cmp = c2[9:0];
        return cmd;
    endfunction

    always @(posedge i_clk) begin
        t_motor_cmd want;
        if (!i_rst_n) begin
            cfg.kp = '0;
            cfg.ki = '0;
            cfg.kd = '0;
            cfg.duty_cap = 10'd999;
            cfg.reverse_drive = 1'b0;
            cfg.integral_limit = 23'h7FFFFF;
            cfg.low_target_limit = '0;
            cfg.low_target_output_limit = 10'd999;
            prev_target = '0;
            integ = 0;
            last_err = 0;
            der_ok = 1'b0;
            cmd_q.delete();
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (cmd_q.size() == 0) begin
                    $error("result transaction with no expected command pending");
                    fail_tally++;
                end else begin
                    want = cmd_q.pop_front();
                    if (i_drive !== want.drive) begin
                        $error("drive: expected %0d, got %0d", want.drive, i_drive);
                        fail_tally++;
                    end
                    if (i_speed_error !== want.speed_error) begin
                        $error("speed_error: expected %0d, got %0d",
                               want.speed_error, i_speed_error);
                        fail_tally++;
                    end
                    if (i_in1_compare !== want.in1_cmp) begin
                        $error("in1_compare: expected %0d, got %0d",
                               want.in1_cmp, i_in1_compare);
                        fail_tally++;
                    end
                    if (i_in2_compare !== want.in2_cmp) begin
                        $error("in2_compare: expected %0d, got %0d",
                               want.in2_cmp, i_in2_compare);
                        fail_tally++;
                    end
                end
            end
            if (i_in_valid && !i_in_stall) begin
                cmd_q.push_back(next_motor_cmd(i_target, i_measured));
            end
            if (i_psel && i_penable && i_pwrite && i_pready) begin
                case (i_paddr[4:2])
                    REG_KP:   cfg.kp = i_pwdata[15:0];
                    REG_KI:   cfg.ki = i_pwdata[15:0];
                    REG_KD:   cfg.kd = i_pwdata[15:0];
                    REG_MAXS: cfg.duty_cap = i_pwdata[9:0];
                    REG_REV:  cfg.reverse_drive = i_pwdata[0];
                    REG_ILIM: cfg.integral_limit = i_pwdata[22:0];
                    REG_LTL:  cfg.low_target_limit = i_pwdata[14:0];
                    REG_LTOL: cfg.low_target_output_limit = i_pwdata[9:0];
                    default: ;
                endcase
            end
        end
        o_pending <= cmd_q.size();
        o_errors <= fail_tally;
    end

endmodule

@@ dv/testbench.sv @@
`timescale 1ns / 100ps

module testbench;
    import psl_pkg::*;

    localparam int CYCLE_LIMIT = 500000;
    localparam int HOLD_CYCLES = 64;
    localparam int PHASES      = 12;
    localparam int PHASE_ITEMS = 38;

    typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} t_idle_mode;

    logic               i_clk;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_stall;
    logic signed [15:0] i_target = '0;
    logic signed [15:0] i_measured = '0;
    logic               o_valid;
    logic               i_stall = 1'b0;
    logic signed [10:0] o_drive;
    logic signed [16:0] o_speed_error;
    logic [9:0]         o_in1_compare;
    logic [9:0]         o_in2_compare;
    logic               psel = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite = 1'b0;
    logic [ADDR_W-1:0]  paddr = '0;
    logic [DATA_W-1:0]  pwdata = '0;
    logic [DATA_W-1:0]  prdata;
    logic               pready;

    int                 mismatches;
    int                 pending;
    int                 cycle_count = 0;
    int                 idle_in_pct = 0;
    int                 stall_pct = 0;
    int                 hold_reqs = 0;
    int                 holds_done = 0;
    logic signed [15:0] track = '0;

    pid_speed_loop_hbridge_pwm dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_target      (i_target),
        .i_measured    (i_measured),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_drive       (o_drive),
        .o_speed_error (o_speed_error),
        .o_in1_compare (o_in1_compare),
        .o_in2_compare (o_in2_compare),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    speed_loop_checker u_chk (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_valid),
        .i_in_stall    (o_stall),
        .i_target      (i_target),
        .i_measured    (i_measured),
        .i_out_valid   (o_valid),
        .i_out_stall   (i_stall),
        .i_drive       (o_drive),
        .i_speed_error (o_speed_error),
        .i_in1_compare (o_in1_compare),
        .i_in2_compare (o_in2_compare),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_pready      (pready),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .o_errors      (mismatches),
        .o_pending     (pending)
    );

    always begin
        i_clk = 1'b0;
        #4;
        i_clk = 1'b1;
        #4;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // receiver side: random stalls, plus long hold-offs on request
    initial begin
        int k;
        forever begin
            @(posedge i_clk);
            if (holds_done != hold_reqs) begin
                holds_done++;
                for (k = 0; k < HOLD_CYCLES; k++) begin
                    i_stall <= 1'b1;
                    @(posedge i_clk);
                end
            end
            i_stall <= (stall_pct != 0) && ($urandom_range(99) < stall_pct);
        end
    end

    task automatic send_item(input logic signed [15:0] tgt, input logic signed [15:0] meas);
        bit taken;
        while (idle_in_pct != 0 && $urandom_range(99) < idle_in_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_target <= tgt;
        i_measured <= meas;
        do begin
            @(negedge i_clk);
            taken = !o_stall;
            @(posedge i_clk);
        end while (!taken);
    endtask

    task automatic write_reg(input logic [2:0] idx, input int val);
        bit done;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 2'b00};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do begin
            @(negedge i_clk);
            done = pready;
            @(posedge i_clk);
        end while (!done);
    endtask

    task automatic load_config(input int kp, input int ki, input int kd, input int maxs,
                               input int rev, input int ilim, input int ltl, input int ltol);
        write_reg(REG_KP, kp);
        write_reg(REG_KI, ki);
        write_reg(REG_KD, kd);
        write_reg(REG_MAXS, maxs);
        write_reg(REG_REV, rev);
        write_reg(REG_ILIM, ilim);
        write_reg(REG_LTL, ltl);
        write_reg(REG_LTOL, ltol);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    task automatic wait_drained();
        i_valid <= 1'b0;
        do @(negedge i_clk); while (pending != 0);
        @(posedge i_clk);
    endtask

    function automatic int pick_gain();
        case ($urandom_range(7))
            0: return -32768;
            1: return 32767;
            2: return int'($urandom_range(65535)) - 32768;
            default: return int'($urandom_range(6000)) - 3000;
        endcase
    endfunction

    function automatic int pick_limit(input int lo_end, input int hi_end, input int span);
        case ($urandom_range(5))
            0: return lo_end;
            1: return hi_end;
            default: return int'($urandom_range(span));
        endcase
    endfunction

    task automatic random_item();
        int                 r;
        logic signed [15:0] t;
        logic signed [15:0] m;
        r = $urandom_range(99);
        if (r >= 60 && r < 75) begin
            track = ($urandom_range(3) == 0) ? 16'($urandom)
                                             : 16'(int'($urandom_range(4000)) - 2000);
        end
        if (r < 75) begin
            // steady tracking around the current target
            t = track;
            m = 16'(int'(track) + int'($urandom_range(400)) - 200);
        end else if (r < 85) begin
            t = '0;
            m = 16'($urandom);
        end else begin
            t = 16'($urandom);
            m = 16'($urandom);
        end
        send_item(t, m);
    endtask

    task automatic run_phase(input t_idle_mode mode, input bit with_hold);
        int k;
        wait_drained();
        load_config(pick_gain(), pick_gain(), pick_gain(), pick_limit(0, 1023, 1023),
                    int'($urandom_range(1)), pick_limit(0, 8388607, 200000),
                    pick_limit(0, 32767, 3000), pick_limit(0, 1023, 1023));
        idle_in_pct = (mode == IDLE_SEND) ? 84 : (mode == IDLE_BOTH) ? 31 : 0;
        stall_pct = (mode == IDLE_RECV) ? 84 : (mode == IDLE_BOTH) ? 31 : 0;
        if (with_hold) hold_reqs++;
        for (k = 0; k < PHASE_ITEMS; k++) begin
            random_item();
        end
    endtask

    initial begin
        int p;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        load_config(1000, 20, 200, 999, 0, 8388607, 0, 999);
        send_item(16'sd0, 16'sd0);
        send_item(16'sd0, -16'sd32768);
        send_item(16'sd0, 16'sd32767);
        send_item(16'sd100, 16'sd0);
        send_item(16'sd100, 16'sd95);
        send_item(16'sd100, 16'sd300);
        send_item(16'sd32767, -16'sd32768);
        send_item(-16'sd32768, 16'sd32767);
        send_item(-16'sd200, -16'sd150);
        send_item(-16'sd200, 16'sd100);
        send_item(-16'sd1, 16'sd0);
        send_item(16'sd1, 16'sd0);

        // out-of-range duty cap, reversed polarity, zero reduced limit
        wait_drained();
        load_config(1000, 0, 0, 1023, 1, 8388607, 32767, 0);
        send_item(16'sd500, 16'sd0);
        send_item(-16'sd500, 16'sd0);
        wait_drained();
        load_config(1000, 0, 0, 1023, 1, 8388607, 32767, 1023);
        send_item(16'sd500, 16'sd0);
        send_item(-16'sd32768, -16'sd32768);
        send_item(-16'sd600, 16'sd0);

        wait_drained();
        load_config(1000, 0, 0, 0, 0, 8388607, 0, 999);
        send_item(16'sd1000, 16'sd0);

        wait_drained();
        load_config(-32768, 32767, -32768, 999, 0, 0, 0, 999);
        send_item(16'sd300, 16'sd0);
        send_item(16'sd300, -16'sd100);
        send_item(-16'sd300, 16'sd0);
        wait_drained();
        load_config(32767, 32767, 32767, 999, 0, 8388607, 0, 999);
        send_item(16'sd32767, -16'sd32768);
        send_item(16'sd32767, -16'sd32768);
        send_item(16'sd20, 16'sd0);

        for (p = 0; p < PHASES; p++) begin
            run_phase(t_idle_mode'(p % 4), (p == 4) || (p == 8));
        end

        wait_drained();
        repeat (20) @(posedge i_clk);
        if (mismatches == 0 && pending == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

@@ pid_speed_loop_hbridge_pwm.f @@
+incdir+hw/rtl
hw/rtl/psl_pkg.sv
hw/rtl/psl_state.sv
hw/rtl/psl_mac.sv
hw/rtl/psl_div.sv
hw/rtl/psl_out.sv
hw/rtl/pid_speed_loop_hbridge_pwm.sv
dv/speed_loop_checker.sv
dv/testbench.sv
